// ----- rtl/remote_link_pairing_handler_unit_defines.svh -----
// Assertion helpers used by rlph_back.
`ifndef REMOTE_LINK_PAIRING_HANDLER_UNIT_DEFINES_SVH
`define REMOTE_LINK_PAIRING_HANDLER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RLP_ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define RLP_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rlph_pkg.sv -----
package rlph_pkg;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_PAIR  = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_ADDR   = 2'd1;
	localparam logic [1:0] KIND_SAVED  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] MODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_PAIRING = 2'd1;
	localparam logic [1:0] MODE_WORKING = 2'd2;

	localparam logic [2:0] REG_BOOT_ADDR = 3'd0;
	localparam logic [2:0] REG_ZERO_POS  = 3'd1;
	localparam logic [2:0] REG_DROP_LINK = 3'd2;
	localparam logic [2:0] REG_BEACON    = 3'd3;
	localparam logic [2:0] REG_COMMIT    = 3'd4;

	localparam logic [7:0] HDR_PAIR  = 8'hcc;
	localparam logic [7:0] HDR_CTRL  = 8'ha5;
	localparam logic [7:0] HDR_REPLY = 8'haa;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic       end_of_packet;
		logic [7:0] bus_status;
		logic [7:0] fault_flags;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic [39:0] pipe_address;
		logic        linked;
		logic [1:0]  work_mode;
		logic        speed_mode;
		logic        direction_mode;
		logic [15:0] position;
		logic        last;
	} out_item_t;

endpackage

// ----- rtl/rlph_if.sv -----
interface rlph_in_if;
	import rlph_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rlph_out_if;
	import rlph_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/remote_link_pairing_handler_unit.sv -----
// Channel  | Dir | Beat
// in_ch    | in  | action, rx_byte, end_of_packet, bus_status, fault_flags
// out_ch   | out | kind, tx_byte, tx_last, pipe_address, link/mode/stick status, last
// cfg      | in  | cfg_we, cfg_idx, cfg_data (plain write, no read-back)
//
// Each byte beat or tick ends in a status beat; a finished packet walks its
// buffer one byte a cycle and then sends up to 9 beats.
// The back sequencer is the limit; a two-entry queue lets the front take
// beats while the back works. Reset clears all control state, the reply
// store and the registers to defaults; the packet buffer is left undefined.
// An output stall holds the sequencer; a full queue drops in_ch.ready, and so
// does a finished packet until the back pops it with its status beat.
module remote_link_pairing_handler_unit #(
	parameter int RX_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	rlph_in_if.sink     in_ch,
	rlph_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [39:0] cfg_data
);
	import rlph_pkg::*;
	localparam int CW = $clog2(RX_BYTES + 1);

	logic              push, full, qv, qdrop, pdrop, pop, rel;
	in_item_t          pitem, qitem;
	logic [CW-1:0]     plen, qlen;
	logic [$clog2(RX_BYTES)-1:0] ridx;
	logic [7:0]        rbyte;

	// Free the packet buffer once its end-of-packet beat leaves the back.
	assign rel = pop && qitem.action == ACT_BYTE && qitem.end_of_packet;

	rlph_front #(.RxBytes(RX_BYTES)) u_front (
		.clk, .arst_n, .in_ch,
		.q_push(push), .q_item(pitem), .q_len(plen), .q_drop(pdrop), .q_full(full),
		.q_rel(rel), .rd_idx(ridx), .rd_byte(rbyte)
	);

	rlph_queue #(.LenW(CW)) u_queue (
		.clk, .arst_n,
		.push, .push_item(pitem), .push_len(plen), .push_drop(pdrop), .full,
		.pop, .valid(qv), .item(qitem), .len(qlen), .drop(qdrop)
	);

	rlph_back #(.RxBytes(RX_BYTES)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.q_valid(qv), .q_item(qitem), .q_len(qlen), .q_drop(qdrop), .q_pop(pop),
		.rd_idx(ridx), .rd_byte(rbyte), .out_ch
	);
endmodule

// ----- rtl/rlph_front.sv -----
// Front: collect packet bytes; pass every item (with packet length) to the queue.
module rlph_front #(
	parameter int RxBytes = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rlph_in_if.sink                      in_ch,
	output logic                         q_push,
	output rlph_pkg::in_item_t           q_item,
	output logic [$clog2(RxBytes+1)-1:0] q_len,
	output logic                         q_drop,
	input  logic                         q_full,
	input  logic                         q_rel,
	input  logic [$clog2(RxBytes)-1:0]   rd_idx,
	output logic [7:0]                   rd_byte
);
	import rlph_pkg::*;
	localparam int CW = $clog2(RxBytes + 1);

	logic [7:0]    store_q [RxBytes];
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          hold_q;
	logic          acc;
	logic          room;

	// Hold the next packet while a finished one still waits in the queue.
	assign in_ch.ready = !q_full && !hold_q;
	assign acc  = in_ch.valid && in_ch.ready;
	assign room = count_q < CW'(RxBytes);

	assign q_push = acc;
	assign q_item = in_ch.data;
	assign q_len  = room ? count_q + CW'(1) : count_q;
	assign q_drop = !room || ovf_q;

	always_ff @(posedge clk) begin
		if (acc && in_ch.data.action == ACT_BYTE && room) begin
			store_q[count_q[$clog2(RxBytes)-1:0]] <= in_ch.data.rx_byte;
		end
	end

	assign rd_byte = store_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (acc && in_ch.data.action == ACT_BYTE && in_ch.data.end_of_packet) begin
			hold_q <= 1'b1;
		end else if (q_rel) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc && in_ch.data.action == ACT_BYTE) begin
			if (in_ch.data.end_of_packet) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end
endmodule

// ----- rtl/rlph_back.sv -----
// Back: run one queued item through a small sequencer and emit its results.
`include "remote_link_pairing_handler_unit_defines.svh"
module rlph_back #(
	parameter int RxBytes = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_idx,
	input  logic [39:0]                  cfg_data,
	input  logic                         q_valid,
	input  rlph_pkg::in_item_t           q_item,
	input  logic [$clog2(RxBytes+1)-1:0] q_len,
	input  logic                         q_drop,
	output logic                         q_pop,
	output logic [$clog2(RxBytes)-1:0]   rd_idx,
	input  logic [7:0]                   rd_byte,
	rlph_out_if.source                   out_ch
);
	import rlph_pkg::*;
	localparam int CW = $clog2(RxBytes + 1);
	localparam int IW = $clog2(RxBytes);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_EVENT = 3'd3;
	localparam logic [2:0] ST_TX    = 3'd4;
	localparam logic [2:0] ST_STAT  = 3'd5;

	logic [2:0]  st_q;
	logic [7:0]  zpos_q, drop_q, bcn_q;
	logic [3:0]  commit_q;

	logic [7:0]  pk_q [6];
	logic [7:0]  reply_q [7];
	logic        link_q;
	logic [1:0]  mode_q;
	logic [3:0]  rep_q;
	logic [7:0]  sil_q, bcnt_q;
	logic [39:0] addr_q;
	logic        spd_q, dir_q;
	logic [15:0] stick_q;

	logic [CW-1:0] idx_q;
	logic [7:0]    sum_q;
	logic [7:0]    lastb_q;
	logic          ev_q;
	logic [1:0]    ev_kind_q;
	logic [2:0]    txi_q;
	logic [2:0]    txn_q;
	logic          tx_go_q;

	logic        ov_q;
	out_item_t   od_q;
	logic        free;
	logic [7:0]  pair_sum, ctrl_sum;
	logic        same_addr;
	logic [39:0] pk_addr;

	assign free = !ov_q || out_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.data  = od_q;
	assign rd_idx = idx_q[IW-1:0];
	assign q_pop = (st_q == ST_STAT) && free;

	assign pk_addr = {pk_q[5], pk_q[4], pk_q[3], pk_q[2], pk_q[1]};
	assign same_addr = pk_addr == {reply_q[5], reply_q[4], reply_q[3], reply_q[2], reply_q[1]};
	assign pair_sum = HDR_PAIR + pk_q[1] + pk_q[2] + pk_q[3] + pk_q[4] + pk_q[5];
	assign ctrl_sum = HDR_REPLY + q_item.bus_status + q_item.fault_flags + HDR_PAIR;

	always_ff @(posedge clk) begin
		if (st_q == ST_SUM && idx_q <= CW'(5)) begin
			pk_q[idx_q[2:0]] <= rd_byte;
		end
		if (st_q == ST_SUM) begin
			lastb_q <= rd_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			zpos_q   <= 8'd100;
			drop_q   <= 8'd250;
			bcn_q    <= 8'd100;
			commit_q <= 4'd5;
			for (int i = 0; i < 7; i++) reply_q[i] <= '0;
			link_q   <= 1'b0;
			mode_q   <= MODE_INIT;
			rep_q    <= '0;
			sil_q    <= '0;
			bcnt_q   <= '0;
			addr_q   <= '0;
			spd_q    <= 1'b0;
			dir_q    <= 1'b0;
			stick_q  <= '0;
			idx_q    <= '0;
			sum_q    <= '0;
			ev_q     <= 1'b0;
			ev_kind_q <= KIND_ADDR;
			txi_q    <= '0;
			txn_q    <= '0;
			tx_go_q  <= 1'b0;
			ov_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_BOOT_ADDR: addr_q <= cfg_data;
					REG_ZERO_POS:  zpos_q <= cfg_data[7:0];
					REG_DROP_LINK: drop_q <= cfg_data[7:0];
					REG_BEACON:    bcn_q <= cfg_data[7:0];
					REG_COMMIT:    commit_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					ev_q    <= 1'b0;
					tx_go_q <= 1'b0;
					txi_q   <= '0;
					idx_q   <= '0;
					sum_q   <= '0;
					if (q_valid) begin
						priority if (q_item.action == ACT_BYTE) begin
							if (q_item.end_of_packet && !q_drop) begin
								sil_q <= '0;
								st_q  <= ST_SUM;
							end else begin
								st_q <= ST_STAT;
							end
						end else if (q_item.action == ACT_TICK) begin
							if (link_q) begin
								if (sil_q > zpos_q) stick_q <= '0;
								if (sil_q > drop_q) begin
									link_q <= 1'b0;
								end else begin
									if (sil_q != 8'hff) sil_q <= sil_q + 8'd1;
									bcnt_q <= '0;
								end
								st_q <= ST_STAT;
							end else begin
								sil_q <= '0;
								if (((bcnt_q != 8'hff) ? bcnt_q + 8'd1 : bcnt_q) >= bcn_q) begin
									bcnt_q  <= '0;
									txn_q   <= 3'd7;
									tx_go_q <= 1'b1;
									st_q    <= ST_TX;
								end else begin
									if (bcnt_q != 8'hff) bcnt_q <= bcnt_q + 8'd1;
									st_q <= ST_STAT;
								end
							end
						end else if (q_item.action == ACT_PAIR) begin
							mode_q    <= MODE_PAIRING;
							addr_q    <= '0;
							ev_q      <= 1'b1;
							ev_kind_q <= KIND_ADDR;
							st_q      <= ST_EVENT;
						end else begin
							st_q <= ST_STAT;
						end
					end
				end
				// Walk the packet buffer one byte a cycle, summing all but the last.
				ST_SUM: begin
					if (idx_q + CW'(1) < q_len) sum_q <= sum_q + rd_byte;
					if (idx_q + CW'(1) >= q_len) st_q <= ST_EVAL;
					else idx_q <= idx_q + CW'(1);
				end
				ST_EVAL: begin
					st_q <= ST_STAT;
					if (q_len == CW'(7) && pk_q[0] == HDR_PAIR && sum_q == lastb_q
						&& mode_q == MODE_PAIRING) begin
						link_q <= 1'b1;
						reply_q[0] <= HDR_PAIR;
						if (same_addr) begin
							if (rep_q > commit_q) begin
								addr_q    <= {reply_q[5], reply_q[4], reply_q[3], reply_q[2], reply_q[1]};
								ev_q      <= 1'b1;
								ev_kind_q <= KIND_ADDR;
							end else if (rep_q != 4'hf) begin
								rep_q <= rep_q + 4'd1;
							end
						end else begin
							rep_q <= '0;
							for (int i = 1; i < 6; i++) reply_q[i] <= pk_q[i];
						end
						reply_q[6] <= pair_sum;
						txn_q   <= 3'd7;
						tx_go_q <= 1'b1;
						st_q    <= ST_EVENT;
					end else if (q_len == CW'(5) && pk_q[0] == HDR_CTRL && sum_q == lastb_q) begin
						if (mode_q == MODE_PAIRING) begin
							ev_q      <= 1'b1;
							ev_kind_q <= KIND_SAVED;
							mode_q    <= MODE_WORKING;
						end
						link_q  <= 1'b1;
						spd_q   <= pk_q[3][0];
						dir_q   <= pk_q[3][1];
						stick_q <= {pk_q[1], pk_q[2]};
						reply_q[0] <= HDR_REPLY;
						reply_q[1] <= q_item.bus_status;
						reply_q[2] <= q_item.fault_flags;
						reply_q[3] <= HDR_PAIR;
						reply_q[4] <= ctrl_sum;
						txn_q   <= 3'd5;
						tx_go_q <= 1'b1;
						st_q    <= ST_EVENT;
					end
				end
				ST_EVENT: begin
					if (!ev_q) begin
						st_q <= tx_go_q ? ST_TX : ST_STAT;
					end else if (free) begin
						ov_q <= 1'b1;
						od_q <= '{kind: ev_kind_q, tx_byte: 8'd0, tx_last: 1'b0,
							pipe_address: addr_q, linked: link_q, work_mode: mode_q,
							speed_mode: spd_q, direction_mode: dir_q, position: stick_q,
							last: 1'b0};
						ev_q <= 1'b0;
						st_q <= tx_go_q ? ST_TX : ST_STAT;
					end
				end
				ST_TX: begin
					if (free) begin
						ov_q <= 1'b1;
						od_q <= '{kind: KIND_TX, tx_byte: reply_q[txi_q],
							tx_last: txi_q == txn_q - 3'd1, pipe_address: 40'd0,
							linked: link_q, work_mode: mode_q, speed_mode: spd_q,
							direction_mode: dir_q, position: stick_q, last: 1'b0};
						if (txi_q == txn_q - 3'd1) st_q <= ST_STAT;
						txi_q <= txi_q + 3'd1;
					end
				end
				ST_STAT: begin
					if (free) begin
						ov_q <= 1'b1;
						od_q <= '{kind: KIND_STATUS, tx_byte: 8'd0, tx_last: 1'b0,
							pipe_address: 40'd0, linked: link_q, work_mode: mode_q,
							speed_mode: spd_q, direction_mode: dir_q, position: stick_q,
							last: 1'b1};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`RLP_ASSERT_IMPL(a_pop_with_item, clk, arst_n, q_pop, q_valid, "pop without queued item")
	`RLP_ASSERT_NEXT(a_pop_gives_status, clk, arst_n, q_pop, ov_q && od_q.last, "pop without status beat")
	`RLP_ASSERT_IMPL(a_stall_holds, clk, arst_n, ov_q && !out_ch.ready && st_q != ST_IDLE, !q_pop, "pop while stalled")
endmodule

// ----- rtl/rlph_queue.sv -----
// Two-entry queue between front and back.
module rlph_queue #(
	parameter int LenW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rlph_pkg::in_item_t push_item,
	input  logic [LenW-1:0]    push_len,
	input  logic               push_drop,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output rlph_pkg::in_item_t item,
	output logic [LenW-1:0]    len,
	output logic               drop
);
	import rlph_pkg::*;
	in_item_t        it_q [2];
	logic [LenW-1:0] len_q [2];
	logic            drop_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign item  = it_q[rp_q];
	assign len   = len_q[rp_q];
	assign drop  = drop_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			it_q[wp_q]   <= push_item;
			len_q[wp_q]  <= push_len;
			drop_q[wp_q] <= push_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import rlph_pkg::*;

	localparam int RX_DEPTH    = 10;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 410;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [39:0] cfg_data;

	rlph_in_if  in_ch ();
	rlph_out_if out_ch ();

	remote_link_pairing_handler_unit #(.RX_BYTES(RX_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Clock: 2 ns period.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Beats waiting to be offered on in_ch, and replies the handler owes us.
	in_item_t  pending_beats[$];
	out_item_t owed_replies[$];
	out_item_t step_results[$];
	int        error_count = 0;
	int        items_queued = 0;
	longint    cycle_count = 0;

	// Predictor copy of the handler: registers first, then link state.
	logic [39:0] boot_addr_reg;
	logic [7:0]  zero_pos_reg, drop_link_reg, beacon_reg;
	logic [3:0]  commit_reg;
	logic [7:0]  pkt_buf [RX_DEPTH];
	int          pkt_len;
	bit          pkt_overflow;
	logic [7:0]  reply_buf [7];
	bit          link_ok;
	logic [1:0]  mode;
	logic [3:0]  repeats;
	logic [7:0]  quiet_ticks, beacon_wait;
	logic [39:0] pipe_addr;
	logic        speed, direction;
	logic [15:0] stick;

	function automatic void emit_result(logic [1:0] k, logic [7:0] b, logic l, logic [39:0] a);
		out_item_t r;
		if (step_results.size() < 9) begin
			r = '0;
			r.kind = k;
			r.tx_byte = b;
			r.tx_last = l;
			r.pipe_address = a;
			step_results.push_back(r);
		end
	endfunction

	function automatic void send_reply_bytes(int len);
		for (int i = 0; i < len; i++)
			emit_result(KIND_TX, reply_buf[i], i == len - 1, '0);
	endfunction

	// Decode a finished packet: pairing echo or control answer.
	function automatic void decode_packet(logic [7:0] bus, logic [7:0] fault);
		logic [7:0] sum;
		bit         same;
		sum = '0;
		for (int i = 0; i + 1 < pkt_len; i++)
			sum = sum + pkt_buf[i];
		if (pkt_len == 7 && pkt_buf[0] == HDR_PAIR && sum == pkt_buf[6]
				&& mode == MODE_PAIRING) begin
			reply_buf[0] = HDR_PAIR;
			link_ok = 1'b1;
			same = 1'b1;
			for (int i = 1; i < 6; i++)
				if (reply_buf[i] != pkt_buf[i]) same = 1'b0;
			if (same) begin
				if (repeats > commit_reg) begin
					pipe_addr = {reply_buf[5], reply_buf[4], reply_buf[3],
						reply_buf[2], reply_buf[1]};
					emit_result(KIND_ADDR, '0, 1'b0, pipe_addr);
				end else if (repeats != 4'hf) begin
					repeats = repeats + 1'b1;
				end
			end else begin
				repeats = '0;
				for (int i = 1; i < 6; i++) reply_buf[i] = pkt_buf[i];
			end
			reply_buf[6] = '0;
			for (int i = 0; i < 6; i++) reply_buf[6] = reply_buf[6] + reply_buf[i];
			send_reply_bytes(7);
		end else if (pkt_len == 5 && pkt_buf[0] == HDR_CTRL && sum == pkt_buf[4]) begin
			if (mode == MODE_PAIRING) begin
				emit_result(KIND_SAVED, '0, 1'b0, pipe_addr);
				mode = MODE_WORKING;
			end
			link_ok = 1'b1;
			speed = pkt_buf[3][0];
			direction = pkt_buf[3][1];
			stick = {pkt_buf[1], pkt_buf[2]};
			reply_buf[0] = HDR_REPLY;
			reply_buf[1] = bus;
			reply_buf[2] = fault;
			reply_buf[3] = HDR_PAIR;
			reply_buf[4] = reply_buf[0] + reply_buf[1] + reply_buf[2] + reply_buf[3];
			send_reply_bytes(5);
		end
	endfunction

	// Work out every result one accepted beat causes, queue them as owed.
	function automatic void predict_beat(in_item_t it);
		out_item_t r;
		step_results = {};
		case (it.action)
			ACT_BYTE: begin
				if (pkt_len < RX_DEPTH) begin
					pkt_buf[pkt_len] = it.rx_byte;
					pkt_len++;
				end else begin
					pkt_overflow = 1'b1;
				end
				if (it.end_of_packet) begin
					if (!pkt_overflow) begin
						quiet_ticks = '0;
						decode_packet(it.bus_status, it.fault_flags);
					end
					pkt_len = 0;
					pkt_overflow = 1'b0;
				end
			end
			ACT_TICK: begin
				if (link_ok) begin
					if (quiet_ticks > zero_pos_reg) stick = '0;
					if (quiet_ticks > drop_link_reg) begin
						link_ok = 1'b0;
					end else begin
						if (quiet_ticks != 8'hff) quiet_ticks++;
						beacon_wait = '0;
					end
				end else begin
					if (beacon_wait != 8'hff) beacon_wait++;
					if (beacon_wait >= beacon_reg) begin
						beacon_wait = '0;
						send_reply_bytes(7);
					end
					quiet_ticks = '0;
				end
			end
			ACT_PAIR: begin
				mode = MODE_PAIRING;
				pipe_addr = '0;
				emit_result(KIND_ADDR, '0, 1'b0, '0);
			end
			default: ;
		endcase
		emit_result(KIND_STATUS, '0, 1'b0, '0);
		foreach (step_results[k]) begin
			r = step_results[k];
			r.linked = link_ok;
			r.work_mode = mode;
			r.speed_mode = speed;
			r.direction_mode = direction;
			r.position = stick;
			r.last = (k == step_results.size() - 1);
			owed_replies.push_back(r);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: hold a beat until it is taken, then advance after a random gap.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_beat(in_ch.data);
				void'(pending_beats.pop_front());
				send_gap = pick_gap();
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_beats[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Monitor: compare each reply beat with the oldest owed one; stall at random,
	// and once hold off long enough that the handler's queue fills and in_ch stalls.
	int beats_seen = 0;
	int stall_left = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				beats_seen++;
				if (owed_replies.size() == 0) begin
					$error("unexpected reply beat kind %0d", got.kind);
					error_count++;
				end else begin
					want = owed_replies.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("tx_last", want.tx_last, got.tx_last);
					check_field("pipe_address", want.pipe_address, got.pipe_address);
					check_field("linked", want.linked, got.linked);
					check_field("work_mode", want.work_mode, got.work_mode);
					check_field("speed_mode", want.speed_mode, got.speed_mode);
					check_field("direction_mode", want.direction_mode, got.direction_mode);
					check_field("position", want.position, got.position);
					check_field("last", want.last, got.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (!long_hold_done && beats_seen >= 60) begin
				long_hold_done = 1'b1;
				stall_left = 600;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				out_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [39:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			REG_BOOT_ADDR: begin
				boot_addr_reg = value;
				pipe_addr = value;
			end
			REG_ZERO_POS:  zero_pos_reg = value[7:0];
			REG_DROP_LINK: drop_link_reg = value[7:0];
			REG_BEACON:    beacon_reg = value[7:0];
			REG_COMMIT:    commit_reg = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(logic [39:0] boot, logic [7:0] zp, logic [7:0] drop,
			logic [7:0] bcn, logic [3:0] commit);
		write_reg(REG_BOOT_ADDR, boot);
		write_reg(REG_ZERO_POS, {32'd0, zp});
		write_reg(REG_DROP_LINK, {32'd0, drop});
		write_reg(REG_BEACON, {32'd0, bcn});
		write_reg(REG_COMMIT, {36'd0, commit});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain: nothing left to send or owed, then let the back end settle.
	task automatic drain();
		while (pending_beats.size() > 0 || owed_replies.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic void queue_beat(logic [1:0] act, logic [7:0] b, logic eop);
		in_item_t it;
		it.action = act;
		it.rx_byte = b;
		it.end_of_packet = eop;
		it.bus_status = $urandom();
		it.fault_flags = $urandom();
		pending_beats.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_packet(logic [7:0] bytes [$]);
		foreach (bytes[i]) queue_beat(ACT_BYTE, bytes[i], i == bytes.size() - 1);
	endfunction

	function automatic void queue_pair_frame(logic [39:0] a, bit spoil);
		logic [7:0] f [$];
		logic [7:0] sum;
		f = {HDR_PAIR, a[7:0], a[15:8], a[23:16], a[31:24], a[39:32]};
		sum = '0;
		foreach (f[i]) sum = sum + f[i];
		f.push_back(spoil ? sum ^ 8'h01 : sum);
		queue_packet(f);
	endfunction

	function automatic void queue_ctrl_frame(logic [15:0] pos, logic [7:0] flags, bit spoil);
		logic [7:0] f [$];
		f = {HDR_CTRL, pos[15:8], pos[7:0], flags};
		f.push_back(f[0] + f[1] + f[2] + f[3] + (spoil ? 8'h80 : 8'h00));
		queue_packet(f);
	endfunction

	// Random traffic: mostly well-formed pairing and control exchanges, plus
	// tick bursts, pairing restarts and junk packets (short, long, bad sum).
	task automatic queue_random_traffic(int count);
		logic [39:0] addr_pool [3];
		logic [7:0]  junk [$];
		int          stop_at;
		int          r;
		int          n;
		foreach (addr_pool[i]) addr_pool[i] = {$urandom(), 8'($urandom())};
		addr_pool[0] = {40{$urandom_range(0, 1) == 1}};
		stop_at = items_queued + count;
		while (items_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				n = $urandom_range(1, 9);
				r = $urandom_range(0, 2);
				repeat (n) queue_pair_frame(addr_pool[r], $urandom_range(0, 19) == 0);
			end else if (r < 50) begin
				queue_ctrl_frame($urandom(), $urandom(), $urandom_range(0, 9) == 0);
			end else if (r < 70) begin
				repeat ($urandom_range(1, 12)) queue_beat(ACT_TICK, $urandom(), $urandom());
			end else if (r < 76) begin
				queue_beat(ACT_PAIR, $urandom(), $urandom());
			end else if (r < 80) begin
				queue_beat(ACT_SPARE, $urandom(), $urandom());
			end else begin
				junk = {};
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 10);
				repeat (n) junk.push_back($urandom());
				if ($urandom_range(0, 1)) junk[0] = ($urandom_range(0, 1)) ? HDR_PAIR : HDR_CTRL;
				queue_packet(junk);
			end
		end
	endtask

	initial begin
		logic [7:0] big [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		// Predictor state after reset.
		boot_addr_reg = '0;
		zero_pos_reg = 8'd100;
		drop_link_reg = 8'd250;
		beacon_reg = 8'd100;
		commit_reg = 4'd5;
		pkt_len = 0;
		pkt_overflow = 1'b0;
		foreach (reply_buf[i]) reply_buf[i] = '0;
		link_ok = 1'b0;
		mode = MODE_INIT;
		repeats = '0;
		quiet_ticks = '0;
		beacon_wait = '0;
		pipe_addr = '0;
		speed = 1'b0;
		direction = 1'b0;
		stick = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unused action, beacon of the cleared reply store, pairing,
		// an all-ones address frame, an extreme control frame, an oversized packet.
		set_registers(40'hff_ffff_ffff, 8'd1, 8'd2, 8'd1, 4'd0);
		queue_beat(ACT_SPARE, 8'hff, 1'b1);
		queue_beat(ACT_TICK, 8'h00, 1'b0);
		queue_beat(ACT_PAIR, 8'h00, 1'b0);
		queue_pair_frame(40'hff_ffff_ffff, 1'b0);
		queue_ctrl_frame(16'h8000, 8'hff, 1'b0);
		big = {};
		repeat (RX_DEPTH + 1) big.push_back(8'hff);
		queue_packet(big);
		drain();

		// Phases: each register setting, extremes included, then random traffic.
		set_registers(40'hff_ffff_ffff, 8'd1, 8'd2, 8'd1, 4'd0);
		queue_random_traffic(100);
		drain();
		set_registers({$urandom(), 8'($urandom())}, 8'd255, 8'd255, 8'd255, 4'd15);
		queue_random_traffic(90);
		drain();
		set_registers(40'd0, 8'd3, 8'd6, 8'd0, 4'd5);
		queue_random_traffic(90);
		drain();
		set_registers({$urandom(), 8'($urandom())}, $urandom_range(1, 20),
			$urandom_range(1, 30), $urandom_range(1, 5), $urandom_range(0, 8));
		queue_random_traffic(ITEM_TARGET - items_queued);
		drain();

		if (error_count == 0 && owed_replies.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rlph_pkg.sv
rtl/rlph_if.sv
rtl/rlph_front.sv
rtl/rlph_back.sv
rtl/rlph_queue.sv
rtl/remote_link_pairing_handler_unit.sv
tb/sv/testbench.sv
